// File: rtl/core/cursor_ordered_list_defines.svh
// ----------------------------------------------------------------------------
// cursor_ordered_list_defines.svh
// Assertion macros shared by the cursor ordered list RTL.
// ----------------------------------------------------------------------------
`ifndef CURSOR_ORDERED_LIST_DEFINES_SVH
`define CURSOR_ORDERED_LIST_DEFINES_SVH

// Same-cycle implication, disabled while reset is asserted.
`define COL_ASSERT_SAME(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("cursor ordered list check failed");

// Next-cycle implication, disabled while reset is asserted.
`define COL_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("cursor ordered list check failed");

`endif

// File: rtl/core/col_pkg.sv
// ----------------------------------------------------------------------------
// col_pkg
// Shared constants, codes and command/status types of the cursor ordered list.
// ----------------------------------------------------------------------------
`default_nettype none

package col_pkg;

  // Store geometry.
  localparam int CAPACITY = 32;
  localparam int DATA_W   = 32;
  localparam int POS_W    = $clog2(CAPACITY);
  localparam int COUNT_W  = $clog2(CAPACITY + 1);

  // Operation codes.
  localparam logic [2:0] OP_START   = 3'd0;
  localparam logic [2:0] OP_ADVANCE = 3'd1;
  localparam logic [2:0] OP_INSERT  = 3'd2;
  localparam logic [2:0] OP_ATTACH  = 3'd3;
  localparam logic [2:0] OP_REMOVE  = 3'd4;

  // Error codes.
  localparam logic [1:0] ERR_OK         = 2'd0;
  localparam logic [1:0] ERR_NO_CURRENT = 2'd1;
  localparam logic [1:0] ERR_FULL       = 2'd2;

  // Datapath state seen by the controller.
  typedef struct packed {
    logic [COUNT_W-1:0] count;
    logic [POS_W-1:0]   pos;
    logic               cur_valid;
  } col_status_t;

  // One step's worth of work for the datapath.
  typedef struct packed {
    logic               exec;
    logic               ins_en;
    logic               rem_en;
    logic [POS_W-1:0]   at_idx;
    logic               word_sel;
    logic [POS_W-1:0]   rd_idx;
    logic [COUNT_W-1:0] next_count;
    logic [POS_W-1:0]   next_pos;
    logic               next_valid;
    logic [1:0]         err;
  } col_cmd_t;

endpackage

`default_nettype wire

// File: rtl/core/col_ctrl.sv
// ----------------------------------------------------------------------------
// col_ctrl
// Handshake state machine and operation decoder of the cursor ordered list.
// ----------------------------------------------------------------------------
`default_nettype none

module col_ctrl (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire logic                in_valid,
  output logic                     in_stall,
  input  wire logic [2:0]          in_operation,
  output logic                     out_valid,
  input  wire logic                out_stall,
  input  wire col_pkg::col_status_t sts,
  output col_pkg::col_cmd_t        cmd
);
  import col_pkg::*;

  // Output register occupancy.
  localparam logic ST_EMPTY = 1'b0;
  localparam logic ST_FULL  = 1'b1;

  logic state_r;
  logic state_nxt;
  logic accept;
  logic full;
  logic [COUNT_W-1:0] pos_ext;
  logic [COUNT_W-1:0] pos_inc;
  logic [COUNT_W-1:0] count_dec;

  // A new item is taken whenever the result register is free or drains now.
  assign out_valid = (state_r == ST_FULL);
  assign in_stall  = out_valid && out_stall;
  assign accept    = in_valid && !in_stall;

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_EMPTY: begin
        if (accept) state_nxt = ST_FULL;
      end
      ST_FULL: begin
        if (!accept && !out_stall) state_nxt = ST_EMPTY;
      end
      default: state_nxt = ST_EMPTY;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_EMPTY;
    end else begin
      state_r <= state_nxt;
    end
  end

  // Decode the operation against the current cursor and count.
  assign full      = (sts.count == COUNT_W'(CAPACITY));
  assign pos_ext   = COUNT_W'(sts.pos);
  assign pos_inc   = pos_ext + COUNT_W'(1);
  assign count_dec = sts.count - COUNT_W'(1);

  always_comb begin
    cmd            = '0;
    cmd.exec       = accept;
    cmd.rd_idx     = sts.pos;
    cmd.next_count = sts.count;
    cmd.next_pos   = sts.pos;
    cmd.next_valid = sts.cur_valid;
    cmd.err        = ERR_OK;
    unique case (in_operation)
      OP_START: begin
        cmd.rd_idx     = '0;
        cmd.next_pos   = '0;
        cmd.next_valid = (sts.count != '0);
      end
      OP_ADVANCE: begin
        if (!sts.cur_valid) begin
          cmd.err = ERR_NO_CURRENT;
        end else if (pos_inc >= sts.count) begin
          cmd.next_valid = 1'b0;
          cmd.next_pos   = '0;
        end else begin
          cmd.next_pos = pos_inc[POS_W-1:0];
          cmd.rd_idx   = pos_inc[POS_W-1:0];
        end
      end
      OP_INSERT: begin
        if (full) begin
          cmd.err = ERR_FULL;
        end else begin
          cmd.ins_en     = 1'b1;
          cmd.word_sel   = 1'b1;
          cmd.at_idx     = sts.cur_valid ? sts.pos : '0;
          cmd.next_pos   = sts.cur_valid ? sts.pos : '0;
          cmd.next_valid = 1'b1;
          cmd.next_count = sts.count + COUNT_W'(1);
        end
      end
      OP_ATTACH: begin
        if (full) begin
          cmd.err = ERR_FULL;
        end else begin
          cmd.ins_en     = 1'b1;
          cmd.word_sel   = 1'b1;
          cmd.at_idx     = sts.cur_valid ? pos_inc[POS_W-1:0] : sts.count[POS_W-1:0];
          cmd.next_pos   = sts.cur_valid ? pos_inc[POS_W-1:0] : sts.count[POS_W-1:0];
          cmd.next_valid = 1'b1;
          cmd.next_count = sts.count + COUNT_W'(1);
        end
      end
      OP_REMOVE: begin
        if (!sts.cur_valid) begin
          cmd.err = ERR_NO_CURRENT;
        end else begin
          // The entry that followed slides into the cursor's place.
          cmd.rem_en     = 1'b1;
          cmd.at_idx     = sts.pos;
          cmd.rd_idx     = pos_inc[POS_W-1:0];
          cmd.next_count = count_dec;
          if (pos_ext >= count_dec) begin
            cmd.next_valid = 1'b0;
            cmd.next_pos   = '0;
          end
        end
      end
      default: begin
        cmd.err = ERR_OK;
      end
    endcase
  end

endmodule

`default_nettype wire

// File: rtl/core/col_datapath.sv
// ----------------------------------------------------------------------------
// col_datapath
// Row of entry cells, cursor and count registers, and the result register.
// ----------------------------------------------------------------------------
`default_nettype none
`include "cursor_ordered_list_defines.svh"

module col_datapath (
  input  wire logic                      clk,
  input  wire logic                      rst_n,
  input  wire col_pkg::col_cmd_t         cmd,
  input  wire logic [col_pkg::DATA_W-1:0] in_entry_value,
  output col_pkg::col_status_t           sts,
  output logic                           out_has_current,
  output logic [col_pkg::DATA_W-1:0]     out_current_value,
  output logic [col_pkg::COUNT_W-1:0]    out_entry_count,
  output logic [1:0]                     out_error_code
);
  import col_pkg::*;

  logic [DATA_W-1:0]  entry_r   [CAPACITY];
  logic [DATA_W-1:0]  entry_nxt [CAPACITY];
  logic [COUNT_W-1:0] count_r;
  logic [POS_W-1:0]   pos_r;
  logic               cur_valid_r;
  logic [DATA_W-1:0]  result_word;

  // Each cell takes its left neighbor on insert and its right one on remove.
  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    always_comb begin
      entry_nxt[i] = entry_r[i];
      if (cmd.ins_en) begin
        if (POS_W'(i) == cmd.at_idx) begin
          entry_nxt[i] = in_entry_value;
        end else if (POS_W'(i) > cmd.at_idx) begin
          if (i > 0) entry_nxt[i] = entry_r[(i > 0) ? i - 1 : 0];
        end
      end else if (cmd.rem_en) begin
        if (POS_W'(i) >= cmd.at_idx && i < CAPACITY - 1) begin
          entry_nxt[i] = entry_r[(i < CAPACITY - 1) ? i + 1 : i];
        end
      end
    end

    always_ff @(posedge clk) begin
      if (cmd.exec) entry_r[i] <= entry_nxt[i];
    end
  end

  // Cursor and count.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r     <= '0;
      pos_r       <= '0;
      cur_valid_r <= 1'b0;
    end else if (cmd.exec) begin
      count_r     <= cmd.next_count;
      pos_r       <= cmd.next_pos;
      cur_valid_r <= cmd.next_valid;
    end
  end

  assign sts.count     = count_r;
  assign sts.pos       = pos_r;
  assign sts.cur_valid = cur_valid_r;

  // The current word is either the new one or a stored entry.
  assign result_word = cmd.word_sel ? in_entry_value : entry_r[cmd.rd_idx];

  always_ff @(posedge clk) begin
    if (cmd.exec) begin
      out_has_current   <= cmd.next_valid;
      out_current_value <= cmd.next_valid ? result_word : '0;
      out_entry_count   <= cmd.next_count;
      out_error_code    <= cmd.err;
    end
  end

  `COL_ASSERT_SAME(a_count_bound, clk, rst_n, 1'b1, count_r <= COUNT_W'(CAPACITY))
  `COL_ASSERT_SAME(a_cursor_in_range, clk, rst_n, cur_valid_r, COUNT_W'(pos_r) < count_r)
  `COL_ASSERT_SAME(a_no_cursor_at_zero, clk, rst_n, !cur_valid_r, pos_r == '0)
  `COL_ASSERT_NEXT(a_hold_when_idle, clk, rst_n, !cmd.exec,
                   $stable(count_r) && $stable(pos_r) && $stable(cur_valid_r))

endmodule

`default_nettype wire

// File: rtl/core/cursor_ordered_list.sv
// ----------------------------------------------------------------------------
// cursor_ordered_list
// Ordered store of up to 32 words with one cursor, one result per operation.
// ----------------------------------------------------------------------------
// Usage:
//   The input channel carries an operation code (start, advance, insert,
//   attach, remove) and a word that insert and attach store. Every accepted
//   item yields exactly one result: cursor validity, the word under the
//   cursor (zero when none), the entry count and an error code.
//   Each operation completes in the cycle it is accepted, since the row of
//   entry cells shifts all entries at once; the result shows on the output
//   in the next cycle. One item per cycle is sustained while the receiver does not stall.
//   The result register frees itself in the same cycle it is taken, so a new
//   item is accepted while the receiver takes the previous result. When the
//   receiver stalls with a result pending, in_stall rises and the result and
//   all state hold until the transfer completes.
//   Reset empties the store, clears the cursor and drops the pending result;
//   no clearing pass is needed, since only entries below the count are read.
// ----------------------------------------------------------------------------
`default_nettype none

module cursor_ordered_list (
  input  wire logic                       clk,
  input  wire logic                       rst_n,
  input  wire logic                       in_valid,
  output logic                            in_stall,
  input  wire logic [2:0]                 in_operation,
  input  wire logic [col_pkg::DATA_W-1:0] in_entry_value,
  output logic                            out_valid,
  input  wire logic                       out_stall,
  output logic                            out_has_current,
  output logic [col_pkg::DATA_W-1:0]      out_current_value,
  output logic [col_pkg::COUNT_W-1:0]     out_entry_count,
  output logic [1:0]                      out_error_code
);
  import col_pkg::*;

  col_status_t sts;
  col_cmd_t    cmd;

  // Handshake and decode.
  col_ctrl u_ctrl (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .in_operation (in_operation),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .sts          (sts),
    .cmd          (cmd)
  );

  // Entry cells, cursor and result register.
  col_datapath u_datapath (
    .clk               (clk),
    .rst_n             (rst_n),
    .cmd               (cmd),
    .in_entry_value    (in_entry_value),
    .sts               (sts),
    .out_has_current   (out_has_current),
    .out_current_value (out_current_value),
    .out_entry_count   (out_entry_count),
    .out_error_code    (out_error_code)
  );

endmodule

`default_nettype wire
